// File: rtl/gch_pkg.sv
// shared types, constants and helpers of the grid colour histogram
package gch_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    // item kinds carried on tuser
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int CHAN_W    = 8;

    // bin store
    localparam int BIN_W    = 11;
    localparam int COUNT_W  = 17;
    localparam int NUM_BINS = 1125;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // quantisation and bin layout
    localparam int LEVEL_W    = 3;
    localparam int LEVEL_STEP = 52;
    localparam int REGION_W   = 4;
    localparam int BLK_W      = 2;
    localparam logic [BLK_W-1:0]    BLK_OUTSIDE     = 2'd3;
    localparam logic [REGION_W-1:0] BLOCKS_PER_ROW  = 4'd3;
    localparam logic [BIN_W-1:0]    BINS_PER_REGION = 11'd125;
    localparam logic [BIN_W-1:0]    BINS_PER_RED    = 11'd25;
    localparam logic [BIN_W-1:0]    BINS_PER_GREEN  = 11'd5;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INC  = 2'd1,
        OP_READ = 2'd2
    } bin_op_t;

    typedef struct packed {
        logic             valid;
        bin_op_t          op;
        logic [BIN_W-1:0] addr;
    } bin_req_t;

    typedef struct packed {
        logic clearing;
        logic read_pending;
    } bin_stat_t;

    typedef struct packed {
        logic             busy;
        logic             in_area;
        logic             last;
        logic [BLK_W-1:0] blk;
    } axis_stat_t;

    function automatic logic [LEVEL_W-1:0] quant_level(input logic [CHAN_W-1:0] v);
        logic [LEVEL_W-1:0] q;
        if (v >= CHAN_W'(4 * LEVEL_STEP)) begin
            q = 3'd4;
        end else if (v >= CHAN_W'(3 * LEVEL_STEP)) begin
            q = 3'd3;
        end else if (v >= CHAN_W'(2 * LEVEL_STEP)) begin
            q = 3'd2;
        end else if (v >= CHAN_W'(LEVEL_STEP)) begin
            q = 3'd1;
        end else begin
            q = 3'd0;
        end
        return q;
    endfunction

endpackage

// File: rtl/gch_axis_track.sv
// position, block index and in-block offset along one image axis
module gch_axis_track
    import gch_pkg::*;
#(
    parameter int MAX_DIM = 1024
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CFG_W-1:0] cfg_dim,
    input  logic             start,
    input  logic             step,
    output axis_stat_t       stat
);

    localparam int PW    = $clog2(MAX_DIM);
    localparam int EW    = PW + 1;
    localparam int DW    = (EW > CFG_W) ? EW : CFG_W;
    localparam int RS    = EW + 2;
    localparam int PRODW = EW + RS;
    localparam logic [PRODW-1:0] RECIP3 = PRODW'(((1 << RS) + 2) / 3);
    localparam int CNT_W = $clog2(PW);

    typedef enum logic [3:0] {
        AX_IDLE = 4'b0001,
        AX_PREP = 4'b0010,
        AX_DIV  = 4'b0100,
        AX_DONE = 4'b1000
    } ax_state_t;

    ax_state_t state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    sub_reg, sub_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    quo_reg, quo_next;
    logic [EW-1:0]    dim_reg;
    logic [PW-1:0]    bsize_reg;

    logic [DW-1:0]    dim_wide;
    logic [EW-1:0]    dim_eff;
    logic [PRODW-1:0] prod;
    logic [PW:0]      trial;
    logic             trial_ge;
    logic [EW-1:0]    pos_inc;
    logic [PW:0]      sub_inc;
    logic             last;

    // clamp to 1..MAX_DIM and divide by three through a reciprocal
    assign dim_wide = DW'(cfg_dim);
    assign dim_eff  = (dim_wide == '0) ? EW'(1) :
                      (dim_wide > DW'(MAX_DIM)) ? EW'(MAX_DIM) : EW'(dim_wide);
    assign prod     = PRODW'(dim_eff) * RECIP3;

    always_ff @(posedge aclk) begin
        dim_reg   <= dim_eff;
        bsize_reg <= PW'(prod >> RS);
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign pos_inc  = {1'b0, pos_reg} + EW'(1);
    assign last     = (pos_inc >= dim_reg);
    assign sub_inc  = {1'b0, sub_reg} + (PW+1)'(1);
    assign trial    = {rem_reg, quo_reg[PW-1]};
    assign trial_ge = (trial >= {1'b0, bsize_reg});

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sub_next   = sub_reg;
        blk_next   = blk_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            AX_IDLE: begin
                if (step) begin
                    if (last) begin
                        pos_next = '0;
                        sub_next = '0;
                        blk_next = '0;
                    end else begin
                        pos_next = PW'(pos_inc);
                        if (blk_reg != BLK_OUTSIDE) begin
                            if (sub_inc == {1'b0, bsize_reg}) begin
                                sub_next = '0;
                                blk_next = blk_reg + 1'b1;
                            end else begin
                                sub_next = PW'(sub_inc);
                            end
                        end
                    end
                end
            end
            AX_PREP: begin
                rem_next   = '0;
                quo_next   = pos_reg;
                cnt_next   = '0;
                state_next = AX_DIV;
            end
            AX_DIV: begin
                // restoring division, one quotient bit a cycle
                rem_next = trial_ge ? PW'(trial - {1'b0, bsize_reg}) : PW'(trial);
                quo_next = {quo_reg[PW-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PW - 1)) begin
                    state_next = AX_DONE;
                end
            end
            AX_DONE: begin
                blk_next   = (quo_reg >= PW'(3)) ? BLK_OUTSIDE : BLK_W'(quo_reg);
                sub_next   = rem_reg;
                state_next = AX_IDLE;
            end
            default: begin
                state_next = AX_IDLE;
            end
        endcase
        if (start) begin
            state_next = AX_PREP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AX_IDLE;
            pos_reg   <= '0;
            sub_reg   <= '0;
            blk_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sub_reg   <= sub_next;
            blk_reg   <= blk_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign stat.busy    = (state_reg != AX_IDLE);
    assign stat.in_area = (bsize_reg != '0) && (blk_reg != BLK_OUTSIDE);
    assign stat.last    = last;
    assign stat.blk     = blk_reg;

endmodule

// File: rtl/gch_bin_store.sv
// count memory with read-modify-write pipeline, forwarding and clearing pass
module gch_bin_store
    import gch_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bin_req_t           req,
    output bin_stat_t          stat,
    output logic               rd_valid,
    output logic [COUNT_W-1:0] rd_count
);

    localparam logic [BIN_W-1:0] CLR_LAST = BIN_W'(NUM_BINS - 1);

    logic [COUNT_W-1:0] mem [NUM_BINS];

    logic               clr_active_reg, clr_active_next;
    logic [BIN_W-1:0]   clr_addr_reg, clr_addr_next;
    logic               b_valid_reg;
    bin_op_t            b_op_reg;
    logic [BIN_W-1:0]   b_addr_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               fwd_reg, fwd_next;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] upd;
    logic               in_range;
    logic               b_we;
    logic               we;
    logic [BIN_W-1:0]   waddr;
    logic [COUNT_W-1:0] wdata;

    // the word written last cycle is not yet in the read data
    assign cur      = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign in_range = (b_addr_reg < BIN_W'(NUM_BINS));

    always_comb begin
        case (b_op_reg)
            OP_INC:  upd = (cur == COUNT_MAX) ? cur : cur + 1'b1;
            default: upd = '0;
        endcase
    end

    assign b_we  = b_valid_reg &&
                   ((b_op_reg == OP_INC) || ((b_op_reg == OP_READ) && in_range));
    assign we    = clr_active_reg || b_we;
    assign waddr = clr_active_reg ? clr_addr_reg : b_addr_reg;
    assign wdata = clr_active_reg ? '0 : upd;

    assign fwd_next        = req.valid && b_we && (req.addr == b_addr_reg);
    assign clr_active_next = clr_active_reg && (clr_addr_reg != CLR_LAST);
    assign clr_addr_next   = clr_addr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[req.addr];
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= upd;
        b_op_reg     <= req.op;
        b_addr_reg   <= req.addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            b_valid_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_next;
            end
            b_valid_reg <= req.valid;
            fwd_reg     <= fwd_next;
        end
    end

    assign stat.clearing     = clr_active_reg;
    assign stat.read_pending = b_valid_reg && (b_op_reg == OP_READ);
    assign rd_valid          = stat.read_pending;
    assign rd_count          = in_range ? cur : '0;

    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !b_valid_reg)
        else $error("bin store: transaction in flight during clearing pass");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && (b_op_reg == OP_INC)) |-> in_range)
        else $error("bin store: pixel bin address out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> ($past(b_we) && b_valid_reg && (b_addr_reg == $past(b_addr_reg))))
        else $error("bin store: forwarding without a matching write");

endmodule

// File: rtl/gch_out_fifo.sv
// small result queue between the bin store and the result channel
module gch_out_fifo
    import gch_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [COUNT_W-1:0]   push_data,
    input  logic                 pop,
    output logic                 out_valid,
    output logic [COUNT_W-1:0]   out_data,
    output logic [OUT_CNT_W-1:0] count
);

    logic [COUNT_W-1:0]   data_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign count     = count_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((count_reg != OUT_CNT_W'(OUT_DEPTH)) || pop))
        else $error("result queue: overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("result queue: underflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue: pointers disagree with fill count");

endmodule

// File: rtl/grid_color_histogram_unit.sv
// top level: 3x3 grid colour histogram over a raster pixel stream
// throughput: one transaction per cycle while s_tready is high, pixels and bin reads alike
// a read's count is registered in the bin store, then pushed into the result queue, which raises m_tvalid
// a write to image_width or image_height holds s_tready low
//   while the block position is re-derived by a bit-serial divider
// reset: synchronous, active low; afterwards a clearing pass over all 1125 words of the count memory
module grid_color_histogram_unit
    import gch_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    // pixel and read transactions
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // red[7:0], green[15:8], blue[23:16],
                                            // bin_index[34:24], zero pad
    input  logic                 s_tuser,   // kind

    // bin counts
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // bin_count[16:0], zero pad
);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [BIN_W-1:0]  bin_index;

    logic s_fire;
    logic pixel_fire;
    logic out_room;
    logic m_fire;

    axis_stat_t col_stat;
    axis_stat_t row_stat;
    bin_stat_t  bin_stat;
    bin_req_t   req;

    logic [LEVEL_W-1:0]  red_q;
    logic [LEVEL_W-1:0]  green_q;
    logic [LEVEL_W-1:0]  blue_q;
    logic [REGION_W-1:0] region;
    logic [BIN_W-1:0]    pixel_addr;

    logic                 rd_valid;
    logic [COUNT_W-1:0]   rd_count;
    logic [COUNT_W-1:0]   fifo_data;
    logic [OUT_CNT_W-1:0] fifo_count;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // unpack the input transaction
    assign red       = s_tdata[7:0];
    assign green     = s_tdata[15:8];
    assign blue      = s_tdata[23:16];
    assign bin_index = s_tdata[34:24];

    // room must be kept for every read still heading for the result queue
    assign out_room = ({1'b0, fifo_count} + (OUT_CNT_W+1)'(bin_stat.read_pending))
                      < (OUT_CNT_W+1)'(OUT_DEPTH);
    assign s_tready = !bin_stat.clearing && !col_stat.busy && !row_stat.busy && out_room;

    assign s_fire     = s_tvalid && s_tready;
    assign pixel_fire = s_fire && (s_tuser == KIND_PIXEL);

    // column and row trackers; rows advance on the last pixel of a line
    gch_axis_track #(
        .MAX_DIM (MAX_WIDTH)
    ) u_col (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_dim (image_width_reg),
        .start   (cfg_we && (cfg_index == REG_IMAGE_WIDTH)),
        .step    (pixel_fire),
        .stat    (col_stat)
    );

    gch_axis_track #(
        .MAX_DIM (MAX_HEIGHT)
    ) u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_dim (image_height_reg),
        .start   (cfg_we && (cfg_index == REG_IMAGE_HEIGHT)),
        .step    (pixel_fire && col_stat.last),
        .stat    (row_stat)
    );

    // bin address: 125 per region, then 25 per red level, 5 per green level
    assign red_q      = quant_level(red);
    assign green_q    = quant_level(green);
    assign blue_q     = quant_level(blue);
    assign region     = REGION_W'(row_stat.blk) * BLOCKS_PER_ROW + REGION_W'(col_stat.blk);
    assign pixel_addr = BIN_W'(region) * BINS_PER_REGION
                      + BIN_W'(red_q) * BINS_PER_RED
                      + BIN_W'(green_q) * BINS_PER_GREEN
                      + BIN_W'(blue_q);

    // pixels outside the grid never reach the memory
    always_comb begin
        req.valid = s_fire &&
                    ((s_tuser == KIND_READ) || (col_stat.in_area && row_stat.in_area));
        if (s_tuser == KIND_READ) begin
            req.op   = OP_READ;
            req.addr = bin_index;
        end else begin
            req.op   = req.valid ? OP_INC : OP_NONE;
            req.addr = pixel_addr;
        end
    end

    gch_bin_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .stat     (bin_stat),
        .rd_valid (rd_valid),
        .rd_count (rd_count)
    );

    // result queue decouples the memory pipeline from m_tready
    assign m_fire = m_tvalid && m_tready;

    gch_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rd_valid),
        .push_data (rd_count),
        .pop       (m_fire),
        .out_valid (m_tvalid),
        .out_data  (fifo_data),
        .count     (fifo_count)
    );

    assign m_tdata = M_TDATA_W'(fifo_data);

endmodule

// File: tb/sv/tb.sv
// self-checking stream testbench for the grid colour histogram unit
module tb;
    import gch_pkg::*;

    // instance parameters, kept here so the checker clamps to the same limits
    localparam int FRAME_MAX_W = 1024;
    localparam int FRAME_MAX_H = 1024;
    localparam int GRID = int'(BLOCKS_PER_ROW);

    // pixels may still sit in the pipeline after the last count comes back;
    // this also covers the read path through the store and the result queue with margin
    localparam int SETTLE_CYCLES = 16;
    // long receiver hold-off, enough to fill the result queue and stall s_tready
    localparam int HOLD_CYCLES = 300;
    // frames of one colour in the closing stretch, on a 3x3 frame one pixel per block
    localparam int FINAL_FRAMES = 2;
    localparam int FEED_AHEAD = 64;
    localparam int BIN_INDEX_TOP = (1 << BIN_W) - 1;
    localparam int CHAN_TOP = (1 << CHAN_W) - 1;

    typedef struct {
        logic              kind;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [BIN_W-1:0]  bin_index;
    } px_txn_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    grid_color_histogram_unit #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // histogram predictor state: frame registers, raster position, count store
    logic [CFG_W-1:0]   cur_width  = IMAGE_WIDTH_RESET;
    logic [CFG_W-1:0]   cur_height = IMAGE_HEIGHT_RESET;
    int unsigned        col_at = 0;
    int unsigned        row_at = 0;
    int unsigned        hist [NUM_BINS];
    logic [COUNT_W-1:0] expected_counts [$];

    // stimulus plumbing
    px_txn_t     pending_txns [$];
    px_txn_t     drv_txn;
    px_txn_t     seen_txn;
    int          txn_in_flight = 0;
    bit          in_taken = 1'b0;
    bit          src_idle_on = 1'b0;
    bit          snk_idle_on = 1'b0;
    int unsigned src_gap = 0;
    int unsigned snk_gap = 0;
    bit          hold_armed = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned hold_left = 0;
    int          mismatches = 0;
    logic [COUNT_W-1:0] want_count;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // reset once, released on a falling edge
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // the store is cleared by reset
    initial begin
        foreach (hist[i]) hist[i] = 0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned lim);
        if (v == '0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // bin of a colour within one grid block, each channel quantised to five levels
    function automatic int unsigned colour_bin(input int unsigned blk,
                                               input int unsigned r,
                                               input int unsigned g,
                                               input int unsigned b);
        return blk * int'(BINS_PER_REGION) + int'(BINS_PER_RED) * (r / LEVEL_STEP)
             + int'(BINS_PER_GREEN) * (g / LEVEL_STEP) + b / LEVEL_STEP;
    endfunction

    // advance the histogram by one accepted transaction
    task automatic apply_txn(input px_txn_t t);
        int unsigned w, h, bw, bh, slot;
        w  = eff_dim(cur_width, FRAME_MAX_W);
        h  = eff_dim(cur_height, FRAME_MAX_H);
        bw = w / GRID;
        bh = h / GRID;
        if (t.kind == KIND_PIXEL) begin
            // only the area covered by whole blocks is counted
            if (bw != 0 && bh != 0 && col_at < GRID * bw && row_at < GRID * bh) begin
                slot = colour_bin(GRID * (row_at / bh) + col_at / bw,
                                  t.red, t.green, t.blue);
                if (hist[slot] < COUNT_MAX) hist[slot]++;
            end
            // a position left outside a shrunken frame wraps on this pixel too
            if (col_at + 1 >= w) begin
                col_at = 0;
                row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
            end else begin
                col_at++;
            end
        end else if (t.bin_index < NUM_BINS) begin
            expected_counts.push_back(COUNT_W'(hist[t.bin_index]));
            hist[t.bin_index] = 0;
        end else begin
            // out-of-range read returns zero and clears nothing
            expected_counts.push_back('0);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ---------------------------------------------------------------- driver

    // presents the next pending transaction once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_txns.size() != 0) begin
                drv_txn = pending_txns.pop_front();
                s_tvalid <= 1'b1;
                // pad, bin_index, blue, green, red from the top down
                s_tdata  <= {5'd0, drv_txn.bin_index, drv_txn.blue, drv_txn.green,
                             drv_txn.red};
                s_tuser  <= drv_txn.kind;
                if (src_idle_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(1, 9);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready: random stall bursts plus one long hold-off when armed
    always @(negedge aclk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_idle_on && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(1, 9);
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                note_mismatch("unrequested bin_count", m_tdata[COUNT_W-1:0], '0);
            end else begin
                want_count = expected_counts.pop_front();
                if (m_tdata[COUNT_W-1:0] !== want_count) begin
                    note_mismatch("bin_count", m_tdata[COUNT_W-1:0], want_count);
                end
            end
        end
        in_taken = s_tvalid && s_tready;
        if (in_taken) begin
            seen_txn.kind      = s_tuser;
            seen_txn.red       = s_tdata[7:0];
            seen_txn.green     = s_tdata[15:8];
            seen_txn.blue      = s_tdata[23:16];
            seen_txn.bin_index = s_tdata[34:24];
            apply_txn(seen_txn);
            txn_in_flight--;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_txn(input px_txn_t t);
        pending_txns.push_back(t);
        txn_in_flight++;
    endtask

    // bin_index of a pixel transaction carries random junk
    task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        px_txn_t t;
        t.kind      = KIND_PIXEL;
        t.red       = r;
        t.green     = g;
        t.blue      = b;
        t.bin_index = BIN_W'($urandom_range(0, BIN_INDEX_TOP));
        push_txn(t);
    endtask

    // colour fields of a read transaction carry random junk
    task automatic push_read(input int unsigned idx);
        px_txn_t t;
        t.kind      = KIND_READ;
        t.red       = CHAN_W'($urandom_range(0, CHAN_TOP));
        t.green     = CHAN_W'($urandom_range(0, CHAN_TOP));
        t.blue      = CHAN_W'($urandom_range(0, CHAN_TOP));
        t.bin_index = BIN_W'(idx);
        push_txn(t);
    endtask

    // everything accepted, every count back, pipeline settled
    task automatic wait_idle();
        while (txn_in_flight != 0 || expected_counts.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // frame size changes only while the block is idle
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        cur_width = w;
        write_reg(REG_IMAGE_HEIGHT, h);
        cur_height = h;
    endtask

    // mostly pixels from a small palette, reads aimed at bins that palette hits
    task automatic random_phase(input int n);
        logic [CHAN_W-1:0] pal [3][3];
        int unsigned roll, pick;
        foreach (pal[c, ch]) pal[c][ch] = CHAN_W'($urandom_range(0, CHAN_TOP));
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 2);
            if (roll < 65) begin
                if ($urandom_range(0, 4) != 0) begin
                    push_pixel(pal[pick][0], pal[pick][1], pal[pick][2]);
                end else begin
                    push_pixel(CHAN_W'($urandom_range(0, CHAN_TOP)),
                               CHAN_W'($urandom_range(0, CHAN_TOP)),
                               CHAN_W'($urandom_range(0, CHAN_TOP)));
                end
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 15) begin
                    push_read(colour_bin($urandom_range(0, GRID * GRID - 1),
                                         pal[pick][0], pal[pick][1], pal[pick][2]));
                end else if (roll < 18) begin
                    push_read($urandom_range(0, NUM_BINS - 1));
                end else begin
                    push_read($urandom_range(NUM_BINS, BIN_INDEX_TOP));
                end
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int n);
        set_frame(w, h);
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
        random_phase(n);
    endtask

    initial begin
        @(posedge aresetn);
        @(negedge aclk);

        // default 640x480 frame: row 0, first pixels fall in block 0
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd51, 8'd52, 8'd103);
        push_pixel(8'd104, 8'd155, 8'd156);
        push_pixel(8'd207, 8'd208, 8'd0);
        push_read(colour_bin(0, 0, 0, 0));
        push_read(colour_bin(0, 255, 255, 255));
        push_read(colour_bin(0, 51, 52, 103));
        push_read(colour_bin(0, 0, 0, 0));          // cleared by the first read
        push_read(NUM_BINS - 1);
        push_read(NUM_BINS);                        // just past the store
        push_read(BIN_INDEX_TOP);

        // leave the position at column 1 of row 1, then shrink the frame under it
        set_frame(11'd10, 11'd10);
        for (int k = 0; k < 6; k++) begin
            push_pixel(CHAN_W'($urandom_range(0, CHAN_TOP)),
                       CHAN_W'($urandom_range(0, CHAN_TOP)),
                       CHAN_W'($urandom_range(0, CHAN_TOP)));
        end
        set_frame(11'd4, 11'd3);
        // first pixels fall in blocks 4 and 5, the third is outside and wraps to row 2, the last is in block 6
        for (int k = 0; k < 4; k++) push_pixel(8'd255, 8'd255, 8'd255);
        push_read(colour_bin(3, 255, 255, 255));
        push_read(colour_bin(4, 255, 255, 255));
        push_read(colour_bin(5, 255, 255, 255));

        // random part over a spread of frame sizes, extremes included
        run_phase(11'd7, 11'd5, 140);
        run_phase(11'd0, 11'd9, 60);                // zero width counts as one
        run_phase(11'd6, 11'd0, 60);                // zero height counts as one
        run_phase(11'd2, 11'd1, 60);                // blocks of size zero
        run_phase(11'd2047, 11'd2047, 140);         // clamped to the maximum
        run_phase(11'd1024, 11'd3, 120);
        run_phase(11'd1, 11'd1, 50);

        // receiver holds off while a burst of reads fills the result queue
        set_frame(11'd3, 11'd3);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        hold_armed  = 1'b1;
        for (int k = 0; k < 40; k++) push_read(colour_bin(k % (GRID * GRID), 0, 0, 0));
        random_phase(110);

        run_phase(11'd12, 11'd9, 150);
        for (int k = 0; k < 4; k++) begin
            run_phase(CFG_W'($urandom_range(3, 16)), CFG_W'($urandom_range(3, 16)), 120);
        end
        run_phase(11'd40, 11'd30, 100);

        // closing stretch, no idling: a few frames of one colour, every block read back
        set_frame(11'd3, 11'd3);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        for (int k = 0; k < GRID * GRID * FINAL_FRAMES; k++) begin
            push_pixel(8'd10, 8'd10, 8'd10);
            while (pending_txns.size() >= FEED_AHEAD) @(negedge aclk);
        end
        for (int k = 0; k < GRID * GRID; k++) push_read(colour_bin(k, 10, 10, 10));
        push_read(colour_bin(0, 10, 10, 10));

        wait_idle();
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #100000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
